// ===== src/gms_pkg.sv =====
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types, codes and constants of the grid metric stencil block.
// ----------------------------------------------------------------------------
package gms_pkg;

   // Default node capacity of the coordinate and metric memories.
   localparam int MAX_NODES_DEF = 4096;

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int NODE_W   = 12;
   localparam int COORD_W  = 32;
   localparam int MET_W    = 40;
   localparam int STATUS_W = 2;
   localparam int DIM_W    = 11;
   localparam int CSR_IDX_W = 1;
   localparam int TOTAL_W  = 2 * DIM_W;

   // Command codes.
   localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_GRID  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 1'd1;

   // Reset value of both grid dimensions.
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd4;
   localparam logic [DIM_W-1:0] DIM_MIN   = 11'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } coord_type;

   typedef struct packed {
      logic signed [MET_W-1:0] xd_xi;
      logic signed [MET_W-1:0] yd_xi;
      logic signed [MET_W-1:0] xd_eta;
      logic signed [MET_W-1:0] yd_eta;
      logic signed [MET_W-1:0] xdd_xi;
      logic signed [MET_W-1:0] ydd_xi;
      logic signed [MET_W-1:0] xdd_eta;
      logic signed [MET_W-1:0] ydd_eta;
   } metric_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [NODE_W-1:0]         node_index;
      logic signed [COORD_W-1:0] x_coord;
      logic signed [COORD_W-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    is_done;
      logic signed [MET_W-1:0] xd_xi;
      logic signed [MET_W-1:0] yd_xi;
      logic signed [MET_W-1:0] xd_eta;
      logic signed [MET_W-1:0] yd_eta;
      logic signed [MET_W-1:0] xdd_xi;
      logic signed [MET_W-1:0] ydd_xi;
      logic signed [MET_W-1:0] xdd_eta;
      logic signed [MET_W-1:0] ydd_eta;
   } rsp_type;

   // Neighbourhood of one node as gathered from the coordinate memory.
   typedef struct packed {
      logic      corner;
      coord_type centre;
      coord_type xi_lo;
      coord_type xi_hi;
      coord_type eta_lo;
      coord_type eta_hi;
   } stencil_type;

endpackage

// ===== src/gms_ram.sv =====
// ----------------------------------------------------------------------------
// gms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gms_calc.sv =====
// ----------------------------------------------------------------------------
// gms_calc
// Metric arithmetic for one node from its gathered neighbourhood.
// ----------------------------------------------------------------------------
module gms_calc (
   input  gms_pkg::stencil_type st,
   output gms_pkg::metric_type  met
);

   logic signed [gms_pkg::MET_W-1:0] dx_xi, dy_xi, dx_eta, dy_eta;
   logic signed [gms_pkg::MET_W-1:0] sx_xi, sy_xi, sx_eta, sy_eta;

   // Central differences and second-difference terms, all exact in 40 bits.
   always_comb begin
      dx_xi  = 40'(st.xi_hi.x) - 40'(st.xi_lo.x);
      dy_xi  = 40'(st.xi_hi.y) - 40'(st.xi_lo.y);
      dx_eta = 40'(st.eta_hi.x) - 40'(st.eta_lo.x);
      dy_eta = 40'(st.eta_hi.y) - 40'(st.eta_lo.y);
      sx_xi  = (40'(st.centre.x) <<< 1) - 40'(st.xi_lo.x) - 40'(st.xi_hi.x);
      sy_xi  = (40'(st.centre.y) <<< 1) - 40'(st.xi_lo.y) - 40'(st.xi_hi.y);
      sx_eta = (40'(st.centre.x) <<< 1) - 40'(st.eta_lo.x) - 40'(st.eta_hi.x);
      sy_eta = (40'(st.centre.y) <<< 1) - 40'(st.eta_lo.y) - 40'(st.eta_hi.y);
   end

   // A corner takes the one-sided difference scaled by four and no second
   // differences; others take doubled central and eightfold second differences.
   always_comb begin
      if (st.corner) begin
         met.xd_xi   = dx_xi <<< 2;
         met.yd_xi   = dy_xi <<< 2;
         met.xd_eta  = dx_eta <<< 2;
         met.yd_eta  = dy_eta <<< 2;
         met.xdd_xi  = '0;
         met.ydd_xi  = '0;
         met.xdd_eta = '0;
         met.ydd_eta = '0;
      end else begin
         met.xd_xi   = dx_xi <<< 1;
         met.yd_xi   = dy_xi <<< 1;
         met.xd_eta  = dx_eta <<< 1;
         met.yd_eta  = dy_eta <<< 1;
         met.xdd_xi  = sx_xi <<< 3;
         met.ydd_xi  = sy_xi <<< 3;
         met.xdd_eta = sx_eta <<< 3;
         met.ydd_eta = sy_eta <<< 3;
      end
   end

endmodule

// ===== src/grid_metric_stencil.sv =====
// ----------------------------------------------------------------------------
// grid_metric_stencil
// Metric terms of a structured curvilinear grid, held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ channel, results leave on the rsp_ channel,
//   grid dimensions are written on the csr_ channel while the block is idle.
//   A load stores one node's coordinates and gives no result, so loads
//   stream at one transfer per cycle while the block is idle.
//   A read presents one node's eight metric values on rsp_ by way of the
//   S_READ state and the output register; no new request is taken before
//   the result has entered the output register. A compute walks every
//   memory entry once: each grid node takes five reads of the single
//   coordinate read port, one compute and one write; each remaining entry
//   up to MAX_NODES is written with zero. It then returns one completion
//   result. A bad grid size or node index gives its result with that
//   status by way of the S_SEND state and the output register.
//   After reset the dimensions are 4 by 4 and reads return zero until the
//   first successful compute. No memory clearing pass is needed. While reset
//   is high no transfer is taken on req_ or csr_.
//   When the receiver stalls, the result is held in the output register and
//   the block waits before delivering the next one.
// ----------------------------------------------------------------------------
module grid_metric_stencil #(
   parameter int MAX_NODES = gms_pkg::MAX_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gms_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gms_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gms_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gms_pkg::DIM_W-1:0]         csr_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);
   localparam logic [2:0] PH_LAST = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_SEND = 4'b0100,
      S_RUN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [gms_pkg::DIM_W-1:0] cols_ff, cols_in, rows_ff, rows_in;
   logic                      computed_ff, computed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   gms_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   gms_pkg::rsp_type          pend_ff, pend_in;
   logic [AW-1:0]             node_ff, node_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [AW-1:0]             ca_ff, ca_in;
   logic [gms_pkg::DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [2:0]                ph_ff, ph_in;
   gms_pkg::coord_type        slot_ff [5];

   logic [gms_pkg::TOTAL_W-1:0] total;
   logic                        grid_ok;
   logic                        out_free;
   logic                        accept;
   logic                        in_grid;
   logic                        i_first, i_last, j_first, j_last, corner;
   logic [AW-1:0]               ny_a, ca_comb;
   logic [2:0]                  slot_idx;

   logic                  crd_we;
   logic [AW-1:0]         crd_waddr, crd_raddr;
   gms_pkg::coord_type    crd_wdata, crd_rdata;
   logic                  met_we;
   logic [AW-1:0]         met_waddr, met_raddr;
   gms_pkg::metric_type   met_wdata, met_rdata, met_calc;
   gms_pkg::stencil_type  st;

   // Grid size checks.
   always_comb begin
      total   = gms_pkg::TOTAL_W'(cols_ff) * gms_pkg::TOTAL_W'(rows_ff);
      grid_ok = (cols_ff >= gms_pkg::DIM_MIN) && (rows_ff >= gms_pkg::DIM_MIN)
                && (32'(total) <= 32'(MAX_NODES));
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Position of the current node within the sweep.
   always_comb begin
      in_grid = (col_ff < cols_ff);
      i_first = (col_ff == '0);
      i_last  = (col_ff == cols_ff - 1'b1);
      j_first = (row_ff == '0);
      j_last  = (row_ff == rows_ff - 1'b1);
      corner  = (i_first || i_last) && (j_first || j_last);
      ny_a    = AW'(rows_ff);
      ca_comb = addr_ff;
      if (!corner) begin
         if (i_first) begin
            ca_comb = ca_comb + ny_a;
         end else if (i_last) begin
            ca_comb = ca_comb - ny_a;
         end
         if (j_first) begin
            ca_comb = ca_comb + 1'b1;
         end else if (j_last) begin
            ca_comb = ca_comb - 1'b1;
         end
      end
   end

   // Coordinate memory read address for each gather phase.
   always_comb begin
      case (ph_ff)
         3'd0: crd_raddr = ca_comb;
         3'd1: crd_raddr = (corner && i_first) ? ca_ff : ca_ff - ny_a;
         3'd2: crd_raddr = (corner && i_last)  ? ca_ff : ca_ff + ny_a;
         3'd3: crd_raddr = (corner && j_first) ? ca_ff : ca_ff - 1'b1;
         3'd4: crd_raddr = (corner && j_last)  ? ca_ff : ca_ff + 1'b1;
         default: crd_raddr = ca_ff;
      endcase
   end

   // Coordinate writes come from load transfers only.
   always_comb begin
      crd_we    = accept && (req_data.action == gms_pkg::ACT_LOAD)
                  && (32'(req_data.node_index) < 32'(MAX_NODES));
      crd_waddr = AW'(req_data.node_index);
      crd_wdata = '{x: req_data.x_coord, y: req_data.y_coord};
   end

   gms_ram #(
      .WIDTH ($bits(gms_pkg::coord_type)),
      .DEPTH (MAX_NODES)
   ) u_crd_ram (
      .clock   (clock),
      .wr_en   (crd_we),
      .wr_addr (crd_waddr),
      .wr_data (crd_wdata),
      .rd_addr (crd_raddr),
      .rd_data (crd_rdata)
   );

   // Gathered neighbourhood feeding the arithmetic.
   always_comb begin
      st.corner = corner;
      st.centre = slot_ff[0];
      st.xi_lo  = slot_ff[1];
      st.xi_hi  = slot_ff[2];
      st.eta_lo = slot_ff[3];
      st.eta_hi = slot_ff[4];
   end

   gms_calc u_calc (
      .st  (st),
      .met (met_calc)
   );

   // Metric writes: computed nodes inside the grid, zero beyond it.
   always_comb begin
      met_we    = (state_ff == S_RUN) && (in_grid ? (ph_ff == PH_LAST) : 1'b1);
      met_waddr = addr_ff;
      met_wdata = in_grid ? met_calc : '0;
      met_raddr = (state_ff == S_IDLE) ? AW'(req_data.node_index) : node_ff;
   end

   gms_ram #(
      .WIDTH ($bits(gms_pkg::metric_type)),
      .DEPTH (MAX_NODES)
   ) u_met_ram (
      .clock   (clock),
      .wr_en   (met_we),
      .wr_addr (met_waddr),
      .wr_data (met_wdata),
      .rd_addr (met_raddr),
      .rd_data (met_rdata)
   );

   assign slot_idx = 3'(ph_ff - 3'd1);

   // Capture of gathered coordinates.
   always_ff @(posedge clock) begin
      if (state_ff == S_RUN && ph_ff != 3'd0 && ph_ff != PH_LAST) begin
         slot_ff[slot_idx] <= crd_rdata;
      end
   end

   // Sequencer for commands, the compute sweep and result delivery.
   always_comb begin
      state_in     = state_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      computed_in  = computed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      node_in      = node_ff;
      addr_in      = addr_ff;
      ca_in        = ca_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ph_in        = ph_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == gms_pkg::CSR_COLUMNS) begin
            cols_in = csr_data;
         end else if (csr_index == gms_pkg::CSR_ROWS) begin
            rows_in = csr_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            pend_in         = '0;
            pend_in.is_done = 1'b0;
            if (accept) begin
               if (req_data.action == gms_pkg::ACT_COMPUTE) begin
                  pend_in.is_done = 1'b1;
                  if (!grid_ok) begin
                     pend_in.status = gms_pkg::STATUS_GRID;
                     state_in       = S_SEND;
                  end else begin
                     addr_in  = '0;
                     col_in   = '0;
                     row_in   = '0;
                     ph_in    = '0;
                     state_in = S_RUN;
                  end
               end else if (req_data.action == gms_pkg::ACT_READ) begin
                  if (!grid_ok) begin
                     pend_in.status = gms_pkg::STATUS_GRID;
                     state_in       = S_SEND;
                  end else if (gms_pkg::TOTAL_W'(req_data.node_index) >= total) begin
                     pend_in.status = gms_pkg::STATUS_RANGE;
                     state_in       = S_SEND;
                  end else begin
                     node_in  = AW'(req_data.node_index);
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in         = '0;
               rsp_data_in.status  = gms_pkg::STATUS_OK;
               if (computed_ff) begin
                  rsp_data_in.xd_xi   = met_rdata.xd_xi;
                  rsp_data_in.yd_xi   = met_rdata.yd_xi;
                  rsp_data_in.xd_eta  = met_rdata.xd_eta;
                  rsp_data_in.yd_eta  = met_rdata.yd_eta;
                  rsp_data_in.xdd_xi  = met_rdata.xdd_xi;
                  rsp_data_in.ydd_xi  = met_rdata.ydd_xi;
                  rsp_data_in.xdd_eta = met_rdata.xdd_eta;
                  rsp_data_in.ydd_eta = met_rdata.ydd_eta;
               end
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         S_RUN: begin
            if (ph_ff == 3'd0) begin
               ca_in = ca_comb;
            end
            if (!in_grid || ph_ff == PH_LAST) begin
               // Node finished: step to the next memory entry.
               ph_in = '0;
               if (in_grid) begin
                  if (j_last) begin
                     row_in = '0;
                     col_in = col_ff + 1'b1;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
               if (addr_ff == LAST_ADDR) begin
                  computed_in = 1'b1;
                  state_in    = S_SEND;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end else begin
               ph_in = ph_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= gms_pkg::DIM_RESET;
         rows_ff      <= gms_pkg::DIM_RESET;
         computed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ph_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         computed_ff  <= computed_in;
         rsp_valid_ff <= rsp_valid_in;
         ph_ff        <= ph_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
      node_ff     <= node_in;
      addr_ff     <= addr_in;
      ca_ff       <= ca_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
   end

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_no_metric_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RUN) |-> !met_we)
      else $error("metric memory written outside a compute sweep");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (ph_ff <= PH_LAST))
      else $error("gather phase out of range");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_done) |->
      (rsp_data_ff.status != gms_pkg::STATUS_RANGE))
      else $error("compute completion carries a range status");
`endif

endmodule
